FILE: hdl/bia_pkg.sv
// shared types and constants for the bitmap index allocator
package bia_pkg;

  localparam int SLOT_W    = 6;
  localparam int CNT_W     = 7;
  localparam int SUB_W     = 3;
  localparam int CID_W     = SLOT_W - SUB_W;
  localparam int CELL_SLOTS = 1 << SUB_W;
  localparam int NUM_CELLS = 1 << CID_W;
  localparam int MAX_SLOTS = NUM_CELLS * CELL_SLOTS;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOWEST   = 1'b1;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_CLAIM   = 2'd1,
    CMD_RELEASE = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_FULL      = 3'd1,
    STAT_TAKEN     = 3'd2,
    STAT_NOT_TAKEN = 3'd3,
    STAT_RANGE     = 3'd4
  } status_t;

  typedef enum logic {
    CS_IDLE,
    CS_SCAN
  } ctrl_state_t;

  // request token travelling along the cell row
  typedef struct packed {
    logic             valid;
    cmd_t             op;
    logic [SUB_W-1:0] sub;
  } tok_t;

  // token injected by the controller into one cell
  typedef struct packed {
    logic             valid;
    logic [CID_W-1:0] target;
    cmd_t             op;
    logic [SUB_W-1:0] sub;
  } inj_t;

  // answer from the cell that finished the token
  typedef struct packed {
    logic              valid;
    status_t           status;
    logic [SLOT_W-1:0] slot;
  } rsp_t;

endpackage

FILE: hdl/bitmap_index_allocator.sv
// top level of the bitmap index allocator: controller and row of slot cells
//
// Request channel (req_valid, req_stall, cmd, slot_index) takes one item at a
// time; result channel (rsp_valid, rsp_stall, granted_slot, status,
// used_count) returns exactly one item per request, in order.
// Occupancy lives in a row of eight cells of eight slots each. Claim and
// release go straight to the cell that owns the slot; allocate sends a token
// along the row, one cell per cycle, from the cell holding the highest
// in-range slot (or cell 0 in compact mode) until a cell with a free
// in-range slot takes it. A new item is taken as soon as the previous
// result has left the internal result register and no token is in the
// row, so full, range and bad commands run at one item per cycle while
// rsp_stall stays low; claim, release and allocate items hold off the
// next request until their token has finished in the row.
// A result waiting under rsp_stall holds its payload; one more finished item
// can wait behind it before req_stall rises.
// Reset (rst, synchronous) clears all occupancy, the count, capacity and
// mode. Writing capacity clears all occupancy and the count.
module bitmap_index_allocator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [bia_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bia_pkg::CNT_W-1:0]     cfg_data,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    cmd,
  input  logic [bia_pkg::SLOT_W-1:0]    slot_index,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [bia_pkg::SLOT_W-1:0]    granted_slot,
  output logic [2:0]                    status,
  output logic [bia_pkg::CNT_W-1:0]     used_count
);
  import bia_pkg::*;

  logic             clear;
  logic             lowest_first;
  logic [CNT_W-1:0] cap_eff;
  inj_t             inj;
  rsp_t             chain_rsp;
  rsp_t             cell_rsp [NUM_CELLS];
  tok_t             to_below [NUM_CELLS];
  tok_t             to_above [NUM_CELLS];
  logic [NUM_CELLS-1:0] rsp_hits;

  bia_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .cmd          (cmd),
    .slot_index   (slot_index),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .granted_slot (granted_slot),
    .status       (status),
    .used_count   (used_count),
    .clear        (clear),
    .lowest_first (lowest_first),
    .cap_eff      (cap_eff),
    .inj          (inj),
    .chain_rsp    (chain_rsp)
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    tok_t above_in;
    tok_t below_in;
    if (i == NUM_CELLS - 1) begin : g_top
      assign above_in = '0;
    end else begin : g_mid_top
      assign above_in = to_below[i+1];
    end
    if (i == 0) begin : g_bot
      assign below_in = '0;
    end else begin : g_mid_bot
      assign below_in = to_above[i-1];
    end

    bia_cell #(
      .CELL_ID (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .clear        (clear),
      .lowest_first (lowest_first),
      .cap_eff      (cap_eff),
      .inj          (inj),
      .from_above   (above_in),
      .from_below   (below_in),
      .to_below     (to_below[i]),
      .to_above     (to_above[i]),
      .rsp          (cell_rsp[i])
    );

    assign rsp_hits[i] = cell_rsp[i].valid;
  end

  always_comb begin
    chain_rsp = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      chain_rsp = rsp_t'(chain_rsp | cell_rsp[i]);
    end
  end

  // at most one cell may answer a token at a time
  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(rsp_hits))
    else $error("more than one cell answered");

  // an allocate token must find a slot before leaving the row
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    !to_below[0].valid && !to_above[NUM_CELLS-1].valid)
    else $error("allocate token left the cell row");

  // failed requests report slot zero
  a_err_slot: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status != STAT_OK |-> granted_slot == '0)
    else $error("nonzero slot on error result");

  // the count never runs past the slot space
  a_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> used_count <= CNT_W'(MAX_SLOTS))
    else $error("used count above slot space");

endmodule

FILE: hdl/bia_cell.sv
// one cell of the occupancy row: eight slot bits and a token stage
module bia_cell #(
  parameter int CELL_ID = 0
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    clear,
  input  logic                    lowest_first,
  input  logic [bia_pkg::CNT_W-1:0] cap_eff,
  input  bia_pkg::inj_t           inj,
  input  bia_pkg::tok_t           from_above,
  input  bia_pkg::tok_t           from_below,
  output bia_pkg::tok_t           to_below,
  output bia_pkg::tok_t           to_above,
  output bia_pkg::rsp_t           rsp
);
  import bia_pkg::*;

  localparam logic [CID_W-1:0] CID = CID_W'(CELL_ID);

  logic [CELL_SLOTS-1:0] bits;
  logic [CELL_SLOTS-1:0] bits_next;
  logic [CELL_SLOTS-1:0] in_range;
  logic [CELL_SLOTS-1:0] free;
  logic [SUB_W-1:0]      pick;
  tok_t                  tok;
  tok_t                  tok_next;

  always_comb begin
    for (int j = 0; j < CELL_SLOTS; j++) begin
      in_range[j] = {1'b0, CID, SUB_W'(j)} < cap_eff;
    end
    free = ~bits & in_range;
    pick = '0;
    if (lowest_first) begin
      for (int j = CELL_SLOTS - 1; j >= 0; j--) begin
        if (free[j]) pick = SUB_W'(j);
      end
    end else begin
      for (int j = 0; j < CELL_SLOTS; j++) begin
        if (free[j]) pick = SUB_W'(j);
      end
    end

    bits_next = bits;
    to_below  = '0;
    to_above  = '0;
    rsp       = '0;
    if (tok.valid) begin
      case (tok.op)
        CMD_ALLOC: begin
          if (|free) begin
            bits_next[pick] = 1'b1;
            rsp.valid  = 1'b1;
            rsp.status = STAT_OK;
            rsp.slot   = {CID, pick};
          end else if (lowest_first) begin
            to_above = tok;
          end else begin
            to_below = tok;
          end
        end
        CMD_CLAIM: begin
          rsp.valid = 1'b1;
          rsp.slot  = {CID, tok.sub};
          if (bits[tok.sub]) begin
            rsp.status = STAT_TAKEN;
          end else begin
            rsp.status = STAT_OK;
            bits_next[tok.sub] = 1'b1;
          end
        end
        CMD_RELEASE: begin
          rsp.valid = 1'b1;
          rsp.slot  = {CID, tok.sub};
          if (!bits[tok.sub]) begin
            rsp.status = STAT_NOT_TAKEN;
          end else begin
            rsp.status = STAT_OK;
            bits_next[tok.sub] = 1'b0;
          end
        end
        default: begin
          rsp.valid  = 1'b1;
          rsp.status = STAT_RANGE;
        end
      endcase
    end

    // at most one token exists in the row, so the sources never collide
    if (inj.valid && inj.target == CID) begin
      tok_next.valid = 1'b1;
      tok_next.op    = inj.op;
      tok_next.sub   = inj.sub;
    end else if (from_above.valid) begin
      tok_next = from_above;
    end else begin
      tok_next = from_below;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      bits <= '0;
    end else begin
      bits <= bits_next;
    end
    if (rst) begin
      tok <= '0;
    end else begin
      tok <= tok_next;
    end
  end

endmodule

FILE: hdl/bia_ctrl.sv
// request decode, configuration, used count and result staging
module bia_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [bia_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bia_pkg::CNT_W-1:0]     cfg_data,
  input  logic                          req_valid,
  output logic                          req_stall,
  input  logic [1:0]                    cmd,
  input  logic [bia_pkg::SLOT_W-1:0]    slot_index,
  output logic                          rsp_valid,
  input  logic                          rsp_stall,
  output logic [bia_pkg::SLOT_W-1:0]    granted_slot,
  output logic [2:0]                    status,
  output logic [bia_pkg::CNT_W-1:0]     used_count,
  output logic                          clear,
  output logic                          lowest_first,
  output logic [bia_pkg::CNT_W-1:0]     cap_eff,
  output bia_pkg::inj_t                 inj,
  input  bia_pkg::rsp_t                 chain_rsp
);
  import bia_pkg::*;

  ctrl_state_t       state;
  ctrl_state_t       state_next;
  logic [CNT_W-1:0]  capacity;
  logic [CNT_W-1:0]  used;
  logic [CNT_W-1:0]  used_next;
  logic [CNT_W-1:0]  last_slot;
  cmd_t              cur_op;
  logic              req_fire;
  logic              done_move;
  logic              imm_valid;
  status_t           imm_status;
  logic              done_valid;
  logic [SLOT_W-1:0] done_slot;
  status_t           done_status;
  logic [CNT_W-1:0]  done_used;

  always_comb begin
    cap_eff   = (capacity > CNT_W'(MAX_SLOTS)) ? CNT_W'(MAX_SLOTS) : capacity;
    last_slot = cap_eff - CNT_W'(1);
    done_move = done_valid && (!rsp_valid || !rsp_stall);
    req_stall = (state != CS_IDLE) || (done_valid && !done_move);
    req_fire  = req_valid && !req_stall;
    clear     = cfg_wr_en && (cfg_index == CFG_CAPACITY);

    inj        = '0;
    imm_valid  = 1'b0;
    imm_status = STAT_OK;
    if (req_fire) begin
      case (cmd_t'(cmd))
        CMD_ALLOC: begin
          if (used >= cap_eff) begin
            imm_valid  = 1'b1;
            imm_status = STAT_FULL;
          end else begin
            inj.valid = 1'b1;
            inj.op    = CMD_ALLOC;
            // start at the end of the live range that the search favors
            inj.target = lowest_first ? '0 : last_slot[SLOT_W-1:SUB_W];
          end
        end
        CMD_CLAIM, CMD_RELEASE: begin
          if ({1'b0, slot_index} >= cap_eff) begin
            imm_valid  = 1'b1;
            imm_status = STAT_RANGE;
          end else begin
            inj.valid  = 1'b1;
            inj.op     = cmd_t'(cmd);
            inj.target = slot_index[SLOT_W-1:SUB_W];
            inj.sub    = slot_index[SUB_W-1:0];
          end
        end
        default: begin
          imm_valid  = 1'b1;
          imm_status = STAT_RANGE;
        end
      endcase
    end

    used_next = used;
    if (chain_rsp.valid && chain_rsp.status == STAT_OK) begin
      used_next = (cur_op == CMD_RELEASE) ? used - CNT_W'(1) : used + CNT_W'(1);
    end

    state_next = state;
    case (state)
      CS_IDLE: if (inj.valid) state_next = CS_SCAN;
      CS_SCAN: if (chain_rsp.valid) state_next = CS_IDLE;
      default: state_next = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= CS_IDLE;
      capacity     <= '0;
      lowest_first <= 1'b0;
      used         <= '0;
      done_valid   <= 1'b0;
      rsp_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_CAPACITY: capacity <= cfg_data;
          CFG_LOWEST:   lowest_first <= cfg_data[0];
          default: ;
        endcase
      end
      used <= clear ? '0 : used_next;
      if (imm_valid || chain_rsp.valid) begin
        done_valid <= 1'b1;
      end else if (done_move) begin
        done_valid <= 1'b0;
      end
      if (done_move) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (inj.valid) cur_op <= inj.op;
    if (imm_valid) begin
      done_slot   <= '0;
      done_status <= imm_status;
      done_used   <= used;
    end else if (chain_rsp.valid) begin
      done_slot   <= (chain_rsp.status == STAT_OK) ? chain_rsp.slot : '0;
      done_status <= chain_rsp.status;
      done_used   <= used_next;
    end
    if (done_move) begin
      granted_slot <= done_slot;
      status       <= done_status;
      used_count   <= done_used;
    end
  end

endmodule

FILE: bench/bia_result_checker.sv
// result checker for the bitmap index allocator: tracks occupancy and compares every result
module bia_result_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [bia_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bia_pkg::CNT_W-1:0]     cfg_data,
  input  logic                          req_valid,
  input  logic                          req_stall,
  input  logic [1:0]                    cmd,
  input  logic [bia_pkg::SLOT_W-1:0]    slot_index,
  input  logic                          rsp_valid,
  input  logic                          rsp_stall,
  input  logic [bia_pkg::SLOT_W-1:0]    granted_slot,
  input  logic [2:0]                    status,
  input  logic [bia_pkg::CNT_W-1:0]     used_count,
  output int                            fail_count,
  output int                            pending
);
  import bia_pkg::*;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    status_t           status;
    logic [CNT_W-1:0]  used;
  } grant_t;

  logic [MAX_SLOTS-1:0] taken;
  logic [CNT_W-1:0]     n_used;
  logic [CNT_W-1:0]     cap_reg;
  logic                 compact;
  grant_t               grants_due[$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report(string what, logic [7:0] got, logic [7:0] want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  // updates the occupancy for one request and returns the result it must give
  function automatic grant_t apply_request(logic [1:0] op, logic [SLOT_W-1:0] idx);
    grant_t r;
    int     lim;
    int     s;
    bit     found;
    lim = (cap_reg > MAX_SLOTS) ? MAX_SLOTS : int'(cap_reg);
    r.slot = '0;
    r.status = STAT_OK;
    found = 1'b0;
    case (op)
      CMD_ALLOC: begin
        r.status = STAT_FULL;
        if (n_used < lim) begin
          for (int k = 0; k < lim; k++) begin
            s = compact ? k : lim - 1 - k;
            if (!found && !taken[s]) begin
              found = 1'b1;
              taken[s] = 1'b1;
              n_used = n_used + 1'b1;
              r.slot = s[SLOT_W-1:0];
              r.status = STAT_OK;
            end
          end
        end
      end
      CMD_CLAIM, CMD_RELEASE: begin
        if (idx >= lim) begin
          r.status = STAT_RANGE;
        end else if (op == CMD_CLAIM) begin
          if (taken[idx]) begin
            r.status = STAT_TAKEN;
          end else begin
            taken[idx] = 1'b1;
            n_used = n_used + 1'b1;
            r.slot = idx;
          end
        end else begin
          if (!taken[idx]) begin
            r.status = STAT_NOT_TAKEN;
          end else begin
            taken[idx] = 1'b0;
            n_used = n_used - 1'b1;
            r.slot = idx;
          end
        end
      end
      default: r.status = STAT_RANGE;
    endcase
    r.used = n_used;
    return r;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      taken = '0;
      n_used = '0;
      cap_reg = '0;
      compact = 1'b0;
      grants_due.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_CAPACITY) begin
          cap_reg = cfg_data;
          taken = '0;
          n_used = '0;
        end else if (cfg_index == CFG_LOWEST) begin
          compact = cfg_data[0];
        end
      end
      if (rsp_valid && !rsp_stall) begin
        if (grants_due.size() == 0) begin
          report("result with no request outstanding", 8'(granted_slot), 8'd0);
        end else begin
          want = grants_due.pop_front();
          if (granted_slot !== want.slot)
            report("granted_slot", 8'(granted_slot), 8'(want.slot));
          if (status !== want.status)
            report("status", 8'(status), 8'(want.status));
          if (used_count !== want.used)
            report("used_count", 8'(used_count), 8'(want.used));
        end
      end
      // a result never leaves in the cycle its item enters, so the pop comes first
      if (req_valid && !req_stall) grants_due.push_back(apply_request(cmd, slot_index));
    end
    pending = grants_due.size();
  end

endmodule

FILE: bench/tb_bitmap_index_allocator.sv
// testbench top for the bitmap index allocator: stimulus, handshakes and verdict
module tb_bitmap_index_allocator;
  import bia_pkg::*;

  localparam int ITEM_TARGET = 800;
  localparam int IDLE_LIMIT  = 2000;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_CAPACITY;
  logic [CNT_W-1:0]     cfg_data = '0;
  logic                 req_valid = 1'b0;
  logic                 req_stall;
  logic [1:0]           cmd = CMD_ALLOC;
  logic [SLOT_W-1:0]    slot_index = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  logic [SLOT_W-1:0]    granted_slot;
  logic [2:0]           status;
  logic [CNT_W-1:0]     used_count;
  int                   fail_count;
  int                   pending;

  int sent = 0;
  int burst_left = 0;
  int stall_mode = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  always #4 clk = ~clk;

  bitmap_index_allocator dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .cmd          (cmd),
    .slot_index   (slot_index),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .granted_slot (granted_slot),
    .status       (status),
    .used_count   (used_count)
  );

  bia_result_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .cmd          (cmd),
    .slot_index   (slot_index),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .granted_slot (granted_slot),
    .status       (status),
    .used_count   (used_count),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // result side backpressure: randomly chosen patterns, each held for a random span
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 3) == 0);
      2: rsp_stall <= ($urandom_range(0, 3) != 0);
      default: rsp_stall <= (stall_left % 5) < 2;
    endcase
  end

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(logic [1:0] op, logic [SLOT_W-1:0] idx);
    if (burst_left == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    req_valid <= 1'b1;
    cmd <= op;
    slot_index <= idx;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    burst_left--;
    sent++;
  endtask

  // hold off requests until every outstanding result is back
  task automatic settle();
    req_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic configure(bit set_cap, logic [CNT_W-1:0] cap, bit set_mode,
                           logic [CNT_W-1:0] mode_word);
    if (set_cap) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_CAPACITY;
      cfg_data <= cap;
      @(posedge clk);
    end
    if (set_mode) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_LOWEST;
      cfg_data <= mode_word;
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [CNT_W-1:0]  cap;
    logic [CNT_W-1:0]  mode_word;
    logic [1:0]        op;
    logic [SLOT_W-1:0] idx;
    bit                set_cap;
    bit                set_mode;
    int                live;
    int                n;
    int                pick;
    int                roll;
    int                alloc_pct;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // zero capacity after reset: allocate is full, everything else out of range
    send_item(CMD_ALLOC, 6'd0);
    send_item(CMD_CLAIM, 6'd0);
    send_item(CMD_RELEASE, 6'd63);
    send_item(CMD_UNKNOWN, 6'd21);
    settle();

    configure(1'b1, 7'd64, 1'b1, 7'd0);
    send_item(CMD_ALLOC, 6'd0);
    send_item(CMD_ALLOC, 6'd63);
    send_item(CMD_CLAIM, 6'd0);
    send_item(CMD_CLAIM, 6'd0);
    send_item(CMD_RELEASE, 6'd5);
    send_item(CMD_RELEASE, 6'd63);
    send_item(CMD_CLAIM, 6'd63);
    send_item(CMD_UNKNOWN, 6'd63);
    settle();

    // compact mode switch keeps the occupancy
    configure(1'b0, 7'd0, 1'b1, 7'd1);
    send_item(CMD_ALLOC, 6'd42);
    send_item(CMD_RELEASE, 6'd0);
    send_item(CMD_ALLOC, 6'd0);
    settle();

    configure(1'b1, 7'd3, 1'b1, 7'd126);
    send_item(CMD_CLAIM, 6'd3);
    send_item(CMD_CLAIM, 6'd2);
    send_item(CMD_ALLOC, 6'd2);
    send_item(CMD_ALLOC, 6'd9);
    send_item(CMD_ALLOC, 6'd0);
    send_item(CMD_RELEASE, 6'd1);
    send_item(CMD_ALLOC, 6'd55);
    settle();

    // oversized capacity behaves as the full row
    configure(1'b1, 7'd127, 1'b0, 7'd0);
    send_item(CMD_CLAIM, 6'd63);
    send_item(CMD_RELEASE, 6'd63);
    live = 64;

    while (sent < ITEM_TARGET) begin
      settle();
      pick = $urandom_range(0, 19);
      case (pick)
        0: cap = 7'd0;
        1, 2: cap = 7'd1;
        3, 4: cap = 7'd2;
        5, 6, 7: cap = 7'd64;
        8: cap = 7'd63;
        9: cap = CNT_W'($urandom_range(65, 127));
        default: cap = CNT_W'($urandom_range(3, 16));
      endcase
      set_cap = ($urandom_range(0, 4) != 0);
      set_mode = ($urandom_range(0, 2) != 0);
      mode_word = CNT_W'($urandom_range(0, 63) * 2 + $urandom_range(0, 1));
      configure(set_cap, cap, set_mode, mode_word);
      if (set_cap) live = (cap > MAX_SLOTS) ? MAX_SLOTS : int'(cap);

      alloc_pct = 20 + 30 * $urandom_range(0, 2);
      n = (live == MAX_SLOTS) ? $urandom_range(60, 130) : $urandom_range(20, 70);
      for (int i = 0; i < n; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) op = CMD_UNKNOWN;
        else if (roll < alloc_pct) op = CMD_ALLOC;
        else if (roll < alloc_pct + (100 - alloc_pct) / 2) op = CMD_CLAIM;
        else op = CMD_RELEASE;
        // mostly slots inside the live range, some anywhere
        if (live > 0 && $urandom_range(0, 9) != 0) idx = SLOT_W'($urandom_range(0, live - 1));
        else idx = SLOT_W'($urandom_range(0, 63));
        send_item(op, idx);
      end
    end

    settle();
    repeat (12) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
